@@ rtl/shzs_pkg.sv @@
package shzs_pkg;

  // Field widths. Samples are plain ADC counts; calibration and threshold fields are 16 bits.
  localparam int SAMPLE_BITS = 12;
  localparam int FIELD_W     = 16;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  // Pedestal minus sixteen times a sample lives on this many bits (plus sign).
  localparam int SCALED_W = (SAMPLE_BITS + 4 > FIELD_W) ? SAMPLE_BITS + 4 : FIELD_W;
  localparam int DIFF_W   = SCALED_W + 1;
  localparam int SDIFF_W  = SAMPLE_BITS + 1;
  localparam int PROD_W   = 2 * FIELD_W;
  localparam int GPROD_W  = 3 * FIELD_W;
  localparam int WPROD_W  = FIELD_W + DIFF_W;
  localparam int RATIO_W  = DIFF_W + 18;
  localparam int CMP_W    = GPROD_W + 1;

  localparam int NUM_CUTS = 6;
  localparam int NUM_WIN  = 3;

  // Fixed-point alignment shifts for the cross-multiplied compares.
  localparam int MC_A_SHIFT = 24;
  localparam int AMP_SHIFT  = 12;
  localparam int DIFF_SHIFT = 16;
  localparam int WIN_SHIFT  = 16;

  // A gain below 1.0 in Q4.12 marks a low-gain channel.
  localparam logic [FIELD_W-1:0] GAIN_ONE = 16'd4096;

  // Ratio limits as numerator over denominator.
  localparam int DATA_LOW_NUM  = -1;
  localparam int DATA_LOW_DEN  = 10;
  localparam int DATA_HIGH_NUM = 7;
  localparam int DATA_HIGH_DEN = 5;
  localparam int OLD_LOW_NUM   = -99999;
  localparam int OLD_LOW_DEN   = 10;
  localparam int OLD_HIGH_NUM  = 1;
  localparam int OLD_HIGH_DEN  = 1;
  localparam int TEST_LOW_NUM  = -1;
  localparam int TEST_LOW_DEN  = 5;
  localparam int TEST_HIGH_NUM = 2;

  // Mode bit positions, in the order the cuts are tried.
  localparam int MODE_MC_A  = 0;
  localparam int MODE_MC_B  = 1;
  localparam int MODE_DATA  = 2;
  localparam int MODE_SHAPE = 3;
  localparam int MODE_BAD   = 4;
  localparam int MODE_TEST  = 5;
  localparam logic [NUM_CUTS-1:0] KNOWN_MODES = 6'b11_1111;

  localparam logic [2:0] STAGE_NONE = 3'd0;

  // Shape windows: first, second and fourth sample.
  localparam int WIN_FIRST  = 0;
  localparam int WIN_SECOND = 1;
  localparam int WIN_FOURTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_BITS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLDER_ERA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_THR_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_THR_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_SECOND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_FOURTH  = 3'd6;

  typedef logic signed [CMP_W-1:0] cmp_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [FIELD_W-1:0]     pedestal;
    logic [FIELD_W-1:0]     noise_rms;
    logic [FIELD_W-1:0]     strip_gain;
    logic                   calib_found;
    logic                   status_bad;
    logic                   channel_dead;
    logic [FIELD_W-1:0]     mc_threshold_1;
    logic [FIELD_W-1:0]     mc_threshold_2;
  } hit_in_t;

  typedef struct packed {
    logic       suppressed;
    logic [2:0] reject_stage;
    logic       mode_error;
  } hit_out_t;

  typedef struct packed {
    logic [NUM_CUTS-1:0]           mode_bits;
    logic                          older_era;
    logic [FIELD_W-1:0]            data_threshold_1;
    logic [FIELD_W-1:0]            data_threshold_2;
    logic [NUM_WIN-1:0][CFG_W-1:0] shape_window;
  } cfg_t;

  // Load enables for the three datapath stages.
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
  } stage_en_t;

  // Per-cut verdicts of one hit, before the mode bits are applied.
  typedef struct packed {
    logic                found;
    logic [NUM_CUTS-1:0] cut;
  } cut_res_t;

endpackage

@@ rtl/shzs_cut_pipe.sv @@
module shzs_cut_pipe (
  input  logic               clk_i,
  input  shzs_pkg::stage_en_t en_i,
  input  shzs_pkg::hit_in_t  hit_i,
  input  shzs_pkg::cfg_t     cfg_i,
  output shzs_pkg::cut_res_t res_o
);

  localparam int DIFF_W  = shzs_pkg::DIFF_W;
  localparam int SDIFF_W = shzs_pkg::SDIFF_W;
  localparam int SCALED_W = shzs_pkg::SCALED_W;
  localparam int PROD_W  = shzs_pkg::PROD_W;
  localparam int GPROD_W = shzs_pkg::GPROD_W;
  localparam int WPROD_W = shzs_pkg::WPROD_W;
  localparam int RATIO_W = shzs_pkg::RATIO_W;
  localparam int FIELD_W = shzs_pkg::FIELD_W;
  localparam int NUM_WIN = shzs_pkg::NUM_WIN;

  typedef struct packed {
    logic signed [DIFF_W-1:0]       dq;
    logic signed [DIFF_W-1:0]       nq;
    logic signed [DIFF_W-1:0]       n3;
    logic [NUM_WIN-1:0][SDIFF_W-1:0] dk;
    logic [PROD_W-1:0]              rms_t1;
    logic [PROD_W-1:0]              rms_t2;
    logic [PROD_W-1:0]              rms_dt1;
    logic [PROD_W-1:0]              rms_dt2;
    logic [FIELD_W-1:0]             gain;
    logic                           gain_zero;
    logic                           bad_chan;
    logic                           found;
  } s1_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0]        dq;
    logic signed [DIFF_W-1:0]        nq;
    logic signed [DIFF_W-1:0]        n3;
    logic [NUM_WIN-1:0][SDIFF_W-1:0] dk;
    logic [PROD_W-1:0]               rms_t1;
    logic [PROD_W-1:0]               rms_t2;
    logic [PROD_W-1:0]               rms_dt1;
    logic [PROD_W-1:0]               rms_dt2;
    logic [GPROD_W-1:0]              rms_t1_gain;
    logic [NUM_WIN-1:0][WPROD_W-1:0] win_lo;
    logic [NUM_WIN-1:0][WPROD_W-1:0] win_hi;
    logic signed [RATIO_W-1:0]       data_lo_lhs;
    logic signed [RATIO_W-1:0]       data_lo_rhs;
    logic signed [RATIO_W-1:0]       data_hi_lhs;
    logic signed [RATIO_W-1:0]       data_hi_rhs;
    logic signed [RATIO_W-1:0]       test_lo_lhs;
    logic signed [RATIO_W-1:0]       test_lo_rhs;
    logic signed [RATIO_W-1:0]       test_hi_rhs;
    logic                            gain_zero;
    logic                            bad_chan;
    logic                            found;
  } s2_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  shzs_pkg::cut_res_t s3_d, s3_q;

  // Stage 1: pedestal and sample differences, noise times threshold products.
  always_comb begin
    logic [SCALED_W-1:0] ped_w, s0_x16, s2_x16, s3_x16;
    ped_w  = SCALED_W'(hit_i.pedestal);
    s0_x16 = SCALED_W'({hit_i.sample_0, 4'b0000});
    s2_x16 = SCALED_W'({hit_i.sample_2, 4'b0000});
    s3_x16 = SCALED_W'({hit_i.sample_3, 4'b0000});
    s1_d.dq = $signed({1'b0, ped_w}) - $signed({1'b0, s2_x16});
    s1_d.nq = $signed({1'b0, ped_w}) - $signed({1'b0, s0_x16});
    s1_d.n3 = $signed({1'b0, ped_w}) - $signed({1'b0, s3_x16});
    s1_d.dk[shzs_pkg::WIN_FIRST]  = $signed({1'b0, hit_i.sample_0}) -
                                    $signed({1'b0, hit_i.sample_2});
    s1_d.dk[shzs_pkg::WIN_SECOND] = $signed({1'b0, hit_i.sample_1}) -
                                    $signed({1'b0, hit_i.sample_2});
    s1_d.dk[shzs_pkg::WIN_FOURTH] = $signed({1'b0, hit_i.sample_3}) -
                                    $signed({1'b0, hit_i.sample_2});
    s1_d.rms_t1  = PROD_W'(hit_i.noise_rms) * PROD_W'(hit_i.mc_threshold_1);
    s1_d.rms_t2  = PROD_W'(hit_i.noise_rms) * PROD_W'(hit_i.mc_threshold_2);
    s1_d.rms_dt1 = PROD_W'(hit_i.noise_rms) * PROD_W'(cfg_i.data_threshold_1);
    s1_d.rms_dt2 = PROD_W'(hit_i.noise_rms) * PROD_W'(cfg_i.data_threshold_2);
    s1_d.gain      = hit_i.strip_gain;
    s1_d.gain_zero = (hit_i.strip_gain == '0);
    s1_d.bad_chan  = hit_i.status_bad || hit_i.channel_dead ||
                     (hit_i.strip_gain < shzs_pkg::GAIN_ONE);
    s1_d.found     = hit_i.calib_found;
  end

  // Stage 2: gain product, shape window bounds times denominator, ratio limits.
  always_comb begin
    logic signed [RATIO_W-1:0] nq_w, dq_w;
    nq_w = RATIO_W'(s1_q.nq);
    dq_w = RATIO_W'(s1_q.dq);
    s2_d.dq      = s1_q.dq;
    s2_d.nq      = s1_q.nq;
    s2_d.n3      = s1_q.n3;
    s2_d.dk      = s1_q.dk;
    s2_d.rms_t1  = s1_q.rms_t1;
    s2_d.rms_t2  = s1_q.rms_t2;
    s2_d.rms_dt1 = s1_q.rms_dt1;
    s2_d.rms_dt2 = s1_q.rms_dt2;
    s2_d.rms_t1_gain = GPROD_W'(s1_q.rms_t1) * GPROD_W'(s1_q.gain);
    for (int k = 0; k < NUM_WIN; k++) begin
      s2_d.win_lo[k] = WPROD_W'($signed(cfg_i.shape_window[k][FIELD_W-1:0])) *
                       WPROD_W'(s1_q.dq);
      s2_d.win_hi[k] = WPROD_W'($signed(cfg_i.shape_window[k][2*FIELD_W-1:FIELD_W])) *
                       WPROD_W'(s1_q.dq);
    end
    // The older limits have no real lower cut and an upper limit of one.
    if (cfg_i.older_era) begin
      s2_d.data_lo_lhs = nq_w * RATIO_W'(shzs_pkg::OLD_LOW_DEN);
      s2_d.data_lo_rhs = dq_w * RATIO_W'(shzs_pkg::OLD_LOW_NUM);
      s2_d.data_hi_lhs = nq_w * RATIO_W'(shzs_pkg::OLD_HIGH_DEN);
      s2_d.data_hi_rhs = dq_w * RATIO_W'(shzs_pkg::OLD_HIGH_NUM);
    end else begin
      s2_d.data_lo_lhs = nq_w * RATIO_W'(shzs_pkg::DATA_LOW_DEN);
      s2_d.data_lo_rhs = dq_w * RATIO_W'(shzs_pkg::DATA_LOW_NUM);
      s2_d.data_hi_lhs = nq_w * RATIO_W'(shzs_pkg::DATA_HIGH_DEN);
      s2_d.data_hi_rhs = dq_w * RATIO_W'(shzs_pkg::DATA_HIGH_NUM);
    end
    s2_d.test_lo_lhs = nq_w * RATIO_W'(shzs_pkg::TEST_LOW_DEN);
    s2_d.test_lo_rhs = dq_w * RATIO_W'(shzs_pkg::TEST_LOW_NUM);
    s2_d.test_hi_rhs = dq_w * RATIO_W'(shzs_pkg::TEST_HIGH_NUM);
    s2_d.gain_zero   = s1_q.gain_zero;
    s2_d.bad_chan    = s1_q.bad_chan;
    s2_d.found       = s1_q.found;
  end

  // Stage 3: all compares; one verdict bit per cut.
  always_comb begin
    shzs_pkg::cmp_t dq_amp, d0_diff;
    shzs_pkg::cmp_t win_num [NUM_WIN];
    shzs_pkg::cmp_t win_lo  [NUM_WIN];
    shzs_pkg::cmp_t win_hi  [NUM_WIN];
    logic [NUM_WIN-1:0] win_out;
    logic dq_pos, dq_zero, amp_mc, amp_dt, diff_mc, diff_dt;
    logic data_ratio, test_ratio;

    dq_zero = (s2_q.dq == '0);
    dq_pos  = !s2_q.dq[DIFF_W-1] && !dq_zero;
    dq_amp  = shzs_pkg::cmp_t'(s2_q.dq) <<< shzs_pkg::AMP_SHIFT;
    d0_diff = shzs_pkg::cmp_t'($signed(s2_q.dk[shzs_pkg::WIN_FIRST])) <<<
              shzs_pkg::DIFF_SHIFT;
    amp_mc  = dq_amp  <= shzs_pkg::cmp_t'(s2_q.rms_t1);
    amp_dt  = dq_amp  <= shzs_pkg::cmp_t'(s2_q.rms_dt1);
    diff_mc = d0_diff <= shzs_pkg::cmp_t'(s2_q.rms_t2);
    diff_dt = d0_diff <= shzs_pkg::cmp_t'(s2_q.rms_dt2);

    // A zero denominator is an infinity of the numerator's sign; zero over
    // zero fails every compare.
    for (int k = 0; k < NUM_WIN; k++) begin
      win_num[k] = shzs_pkg::cmp_t'($signed(s2_q.dk[k])) <<< shzs_pkg::WIN_SHIFT;
      win_lo[k]  = shzs_pkg::cmp_t'($signed(s2_q.win_lo[k]));
      win_hi[k]  = shzs_pkg::cmp_t'($signed(s2_q.win_hi[k]));
      if (dq_zero) begin
        win_out[k] = (s2_q.dk[k] != '0);
      end else if (dq_pos) begin
        win_out[k] = (win_num[k] < win_lo[k]) || (win_num[k] > win_hi[k]);
      end else begin
        win_out[k] = (win_num[k] > win_lo[k]) || (win_num[k] < win_hi[k]);
      end
    end

    data_ratio = (s2_q.data_lo_lhs < s2_q.data_lo_rhs) ||
                 (s2_q.data_hi_lhs >= s2_q.data_hi_rhs);
    test_ratio = (s2_q.test_lo_lhs < s2_q.test_lo_rhs) ||
                 (RATIO_W'(s2_q.nq) > s2_q.test_hi_rhs);

    s3_d.found = s2_q.found;
    s3_d.cut[shzs_pkg::MODE_MC_A] = s2_q.gain_zero ? s2_q.n3[DIFF_W-1] :
        ((shzs_pkg::cmp_t'(s2_q.n3) <<< shzs_pkg::MC_A_SHIFT) <=
         shzs_pkg::cmp_t'(s2_q.rms_t1_gain));
    s3_d.cut[shzs_pkg::MODE_MC_B]  = diff_mc || amp_mc;
    s3_d.cut[shzs_pkg::MODE_DATA]  = dq_pos ? (data_ratio || amp_dt) : (diff_dt || amp_dt);
    s3_d.cut[shzs_pkg::MODE_SHAPE] = |win_out;
    s3_d.cut[shzs_pkg::MODE_BAD]   = s2_q.bad_chan;
    s3_d.cut[shzs_pkg::MODE_TEST]  = dq_pos ? (test_ratio || amp_dt) : (diff_dt || amp_dt);
  end

  // Stage registers; each loads when it is empty or the stage after it can take its content.
  always_ff @(posedge clk_i) begin
    if (en_i.ld_s1) begin
      s1_q <= s1_d;
    end
    if (en_i.ld_s2) begin
      s2_q <= s2_d;
    end
    if (en_i.ld_s3) begin
      s3_q <= s3_d;
    end
  end

  assign res_o = s3_q;

endmodule

@@ rtl/strip_hit_zero_suppression_unit.sv @@
// Zero suppression for strip hits: each transaction carries four ADC samples with the strip's
// calibration and flags, and returns one verdict (suppressed, first rejecting cut, mode error).
// The unit takes one hit per clock unless stalled; a hit passes three arithmetic stages
// (differences and noise products, gain and window products, compares) and the output register,
// where the enabled cuts are applied in bit order. Every stage holds its own valid bit, so a
// stall on the output side only backs up as far as the first empty stage. Write configuration
// through the plain write port only while no hit is in flight; the unit itself never checks.
module strip_hit_zero_suppression_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  shzs_pkg::hit_in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output shzs_pkg::hit_out_t                    out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [shzs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [shzs_pkg::CFG_W-1:0]            cfg_wdata_i
);

  shzs_pkg::cfg_t      cfg_d, cfg_q;
  shzs_pkg::stage_en_t stage_en;
  shzs_pkg::cut_res_t  cut_res;
  shzs_pkg::hit_out_t  out_d, out_q;
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic ready1, ready2, ready3, out_ready;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        shzs_pkg::CFG_MODE_BITS:
          cfg_d.mode_bits = cfg_wdata_i[shzs_pkg::NUM_CUTS-1:0];
        shzs_pkg::CFG_OLDER_ERA:
          cfg_d.older_era = cfg_wdata_i[0];
        shzs_pkg::CFG_DATA_THR_1:
          cfg_d.data_threshold_1 = cfg_wdata_i[shzs_pkg::FIELD_W-1:0];
        shzs_pkg::CFG_DATA_THR_2:
          cfg_d.data_threshold_2 = cfg_wdata_i[shzs_pkg::FIELD_W-1:0];
        shzs_pkg::CFG_SHAPE_FIRST:
          cfg_d.shape_window[shzs_pkg::WIN_FIRST] = cfg_wdata_i;
        shzs_pkg::CFG_SHAPE_SECOND:
          cfg_d.shape_window[shzs_pkg::WIN_SECOND] = cfg_wdata_i;
        shzs_pkg::CFG_SHAPE_FOURTH:
          cfg_d.shape_window[shzs_pkg::WIN_FOURTH] = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A stage takes new content when it is empty or its content moves on.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign ready3    = !v3_q || out_ready;
  assign ready2    = !v2_q || ready3;
  assign ready1    = !v1_q || ready2;
  assign in_stall_o = !ready1;

  assign stage_en.ld_s1 = ready1;
  assign stage_en.ld_s2 = ready2;
  assign stage_en.ld_s3 = ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (out_ready) begin
        out_valid_q <= v3_q;
      end
    end
  end

  shzs_cut_pipe u_cut_pipe (
    .clk_i (clk_i),
    .en_i  (stage_en),
    .hit_i (in_data_i),
    .cfg_i (cfg_q),
    .res_o (cut_res)
  );

  // Apply the enabled cuts; the lowest enabled cut that rejects names the stage.
  always_comb begin
    logic [shzs_pkg::NUM_CUTS-1:0] hits;
    logic active;
    active = cut_res.found && (cfg_q.mode_bits != '0);
    hits   = active ? (cut_res.cut & cfg_q.mode_bits) : '0;
    out_d.suppressed   = |hits;
    out_d.reject_stage = shzs_pkg::STAGE_NONE;
    for (int k = shzs_pkg::NUM_CUTS - 1; k >= 0; k--) begin
      if (hits[k]) begin
        out_d.reject_stage = 3'(k + 1);
      end
    end
    out_d.mode_error = active && ((cfg_q.mode_bits & shzs_pkg::KNOWN_MODES) == '0);
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A verdict names a stage exactly when the hit is suppressed.
  a_stage_matches_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.suppressed ==
                     (out_data_o.reject_stage != shzs_pkg::STAGE_NONE)))
    else $error("reject stage disagrees with suppressed flag");

  // The rejecting stage must be an enabled cut.
  a_stage_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.suppressed) |->
      cfg_q.mode_bits[3'(out_data_o.reject_stage - 3'd1)])
    else $error("hit rejected by a disabled cut");

  // With no stall downstream the pipeline never holds off the input.
  a_no_stall_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import shzs_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_LEN       = 80;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_HITS     = 78;
  localparam int CMP_NAN        = 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  hit_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hit_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Hits waiting to be offered, and verdicts waiting to come out.
  hit_in_t  hit_q[$];
  hit_out_t verdict_q[$];
  cfg_t     cut_cfg = '0;

  int   mismatch_cnt = 0;
  int   n_acc = 0;
  int   n_res = 0;
  int   idle_cnt = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   pat_kind = 0;
  int   pat_left = 0;

  strip_hit_zero_suppression_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sign of n/d minus bn/bd, with bd positive. A zero denominator acts as an
  // infinity of the numerator's sign; zero over zero is unordered.
  function automatic int cross_sign(longint n, longint d, longint bn, longint bd);
    longint lhs, rhs;
    if (d == 0) begin
      if (n > 0) return 1;
      if (n < 0) return -1;
      return CMP_NAN;
    end
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    lhs = n * bd;
    rhs = bn * d;
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  // True when n/d falls below the low bound or above the high bound of a
  // signed Q4.12 window word.
  function automatic logic window_miss(longint n, longint d, logic [CFG_W-1:0] win);
    logic signed [15:0] lo16, hi16;
    longint             lo_b, hi_b;
    lo16 = win[15:0];
    hi16 = win[31:16];
    lo_b = lo16;
    hi_b = hi16;
    return cross_sign(n, d, lo_b, 4096) == -1 || cross_sign(n, d, hi_b, 4096) == 1;
  endfunction

  // Amplitude-ratio cut shared by the data and test modes. The data mode
  // rejects a ratio equal to the upper limit, the test mode does not.
  function automatic logic ratio_reject(longint p, longint s0, longint s2, longint rms,
                                        logic strict_high, longint an, longint ad,
                                        longint bn, longint bd);
    longint dq, nq, thr1, thr2;
    logic   amp, lo;
    int     c;
    thr1 = cut_cfg.data_threshold_1;
    thr2 = cut_cfg.data_threshold_2;
    dq = p - 16 * s2;
    amp = (dq * 4096 <= rms * thr1);
    if (dq > 0) begin
      nq = p - 16 * s0;
      lo = (cross_sign(nq, dq, an, ad) == -1);
      c = cross_sign(nq, dq, bn, bd);
      if (strict_high) return lo || c == 1 || amp;
      return lo || c == 0 || c == 1 || amp;
    end
    return ((s0 - s2) * 65536 <= rms * thr2) || amp;
  endfunction

  // Expected verdict of one hit under the current register settings.
  function automatic hit_out_t predict_verdict(hit_in_t h);
    longint   s0, s1, s2, s3, p, rms, g, t1, t2, dq;
    logic     sup, ran;
    logic [2:0] stage;
    int       c;
    hit_out_t r;
    s0 = h.sample_0;
    s1 = h.sample_1;
    s2 = h.sample_2;
    s3 = h.sample_3;
    p = h.pedestal;
    rms = h.noise_rms;
    g = h.strip_gain;
    t1 = h.mc_threshold_1;
    t2 = h.mc_threshold_2;
    r = '0;
    if (!h.calib_found || cut_cfg.mode_bits == '0) return r;
    sup = 1'b0;
    ran = 1'b0;
    stage = STAGE_NONE;
    dq = p - 16 * s2;
    for (int k = 0; k < NUM_CUTS && !sup; k++) begin
      if (cut_cfg.mode_bits[k]) begin
        ran = 1'b1;
        case (k)
          MODE_MC_A: begin
            c = cross_sign((p - 16 * s3) * 256, g, rms * t1, 65536);
            sup = (c == -1 || c == 0);
          end
          MODE_MC_B: sup = ((s0 - s2) * 65536 <= rms * t2) || (dq * 4096 <= rms * t1);
          MODE_DATA: begin
            if (cut_cfg.older_era)
              sup = ratio_reject(p, s0, s2, rms, 1'b0, OLD_LOW_NUM, OLD_LOW_DEN,
                                 OLD_HIGH_NUM, OLD_HIGH_DEN);
            else
              sup = ratio_reject(p, s0, s2, rms, 1'b0, DATA_LOW_NUM, DATA_LOW_DEN,
                                 DATA_HIGH_NUM, DATA_HIGH_DEN);
          end
          MODE_SHAPE: begin
            sup = window_miss(16 * (s0 - s2), dq, cut_cfg.shape_window[WIN_FIRST]) ||
                  window_miss(16 * (s1 - s2), dq, cut_cfg.shape_window[WIN_SECOND]) ||
                  window_miss(16 * (s3 - s2), dq, cut_cfg.shape_window[WIN_FOURTH]);
          end
          MODE_BAD: sup = h.status_bad || h.channel_dead || (h.strip_gain < GAIN_ONE);
          // The test upper limit is a whole number, so its denominator is one.
          default: sup = ratio_reject(p, s0, s2, rms, 1'b1, TEST_LOW_NUM, TEST_LOW_DEN,
                                      TEST_HIGH_NUM, 1);
        endcase
        if (sup) stage = 3'(k + 1);
      end
    end
    r.suppressed = sup;
    r.reject_stage = stage;
    r.mode_error = !ran;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s in result %0d: got %0h, expected %0h", what, n_res, got, want);
    mismatch_cnt++;
  endtask

  // Sample both handshakes, predict accepted hits and check delivered verdicts.
  always @(posedge clk) begin : check_p
    hit_out_t want;
    in_took = in_valid && !in_stall;
    out_took = out_valid && !out_stall;
    if (in_took) begin
      verdict_q.push_back(predict_verdict(in_data));
      n_acc++;
    end
    if (out_took) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", 8'(out_data), 8'h0);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.suppressed !== want.suppressed)
          report_mismatch("suppressed", 8'(out_data.suppressed), 8'(want.suppressed));
        if (out_data.reject_stage !== want.reject_stage)
          report_mismatch("reject_stage", 8'(out_data.reject_stage), 8'(want.reject_stage));
        if (out_data.mode_error !== want.mode_error)
          report_mismatch("mode_error", 8'(out_data.mode_error), 8'(want.mode_error));
      end
      n_res++;
    end
    if (in_took || out_took) idle_cnt = 0;
    else idle_cnt++;
  end

  // Sender: offers queued hits in bursts of random length with random gaps.
  always @(negedge clk) begin : drive_p
    logic    nv;
    hit_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!in_valid || in_took) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (hit_q.size() != 0) begin
        nd = hit_q.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Receiver: stalls on a changing pattern, plus one long hold-off so that
  // the pipeline fills and backs up into the input.
  always @(negedge clk) begin : stall_p
    logic ns;
    if (!hold_done && n_acc >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (pat_left == 0) begin
      pat_kind = $urandom_range(0, 3);
      pat_left = $urandom_range(20, 80);
    end else begin
      pat_left--;
    end
    case (pat_kind)
      0:       ns = 1'b0;
      1:       ns = ($urandom_range(0, 3) == 0);
      2:       ns = ($urandom_range(0, 1) == 0);
      default: ns = ($urandom_range(0, 7) != 0);
    endcase
    if (hold_left > 0) begin
      ns = 1'b1;
      hold_left--;
    end
    out_stall <= ns;
  end

  // Ends the run when no transaction moves for too long.
  initial begin : watchdog_p
    while (idle_cnt < WATCHDOG_LIMIT) @(negedge clk);
    $display("strip_hit_zero_suppression_unit regression: fail");
    $finish;
  end

  // One register write, mirrored into the predictor's copy of the settings.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE_BITS:    cut_cfg.mode_bits = val[NUM_CUTS-1:0];
      CFG_OLDER_ERA:    cut_cfg.older_era = val[0];
      CFG_DATA_THR_1:   cut_cfg.data_threshold_1 = val[FIELD_W-1:0];
      CFG_DATA_THR_2:   cut_cfg.data_threshold_2 = val[FIELD_W-1:0];
      CFG_SHAPE_FIRST:  cut_cfg.shape_window[WIN_FIRST] = val;
      CFG_SHAPE_SECOND: cut_cfg.shape_window[WIN_SECOND] = val;
      CFG_SHAPE_FOURTH: cut_cfg.shape_window[WIN_FOURTH] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every offered hit has been accepted and every verdict seen.
  task automatic wait_drained();
    while (hit_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Fills the bits above a register's width with junk that must be ignored.
  function automatic logic [CFG_W-1:0] padded(logic [CFG_W-1:0] v, int w);
    logic [63:0] mask;
    mask = (64'd1 << w) - 64'd1;
    return (CFG_W'($urandom) & ~mask[CFG_W-1:0]) | (v & mask[CFG_W-1:0]);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(128, 1536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    int lo, hi;
    lo = $urandom_range(0, 2048);
    hi = $urandom_range(3072, 5632);
    lo = lo - 1024;
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return {16'h7FFF, 16'h8000};
      3:       return CFG_W'($urandom);
      default: return {16'(hi), 16'(lo)};
    endcase
  endfunction

  task automatic random_setup();
    logic [NUM_CUTS-1:0] mode;
    case ($urandom_range(0, 9))
      0:       mode = '0;
      1:       mode = '1;
      2, 3:    mode = NUM_CUTS'(1 << $urandom_range(0, NUM_CUTS - 1));
      default: mode = NUM_CUTS'($urandom_range(1, 63));
    endcase
    write_reg(CFG_MODE_BITS, padded(CFG_W'(mode), NUM_CUTS));
    write_reg(CFG_OLDER_ERA, padded(CFG_W'($urandom_range(0, 1)), 1));
    write_reg(CFG_DATA_THR_1, padded(CFG_W'(pick_threshold()), FIELD_W));
    write_reg(CFG_DATA_THR_2, padded(CFG_W'(pick_threshold()), FIELD_W));
    write_reg(CFG_SHAPE_FIRST, pick_window());
    write_reg(CFG_SHAPE_SECOND, pick_window());
    write_reg(CFG_SHAPE_FOURTH, pick_window());
  endtask

  // One sample of a negative pulse: the pedestal minus a share of the amplitude.
  function automatic logic [SAMPLE_BITS-1:0] pulse_sample(int base, int amp, int lo_pct,
                                                          int hi_pct);
    int pct, jitter, v;
    pct = $urandom_range(lo_pct, hi_pct);
    jitter = $urandom_range(0, 8);
    v = base - (amp * pct) / 100 + jitter - 4;
    if (v < 0) v = 0;
    if (v > (1 << SAMPLE_BITS) - 1) v = (1 << SAMPLE_BITS) - 1;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // A plausible hit: pulse peaking at the third sample over a calibrated pedestal.
  function automatic hit_in_t shaped_hit();
    hit_in_t h;
    int      base, amp, ped;
    base = $urandom_range(100, 3900);
    amp = $urandom_range(0, (base > 2500) ? 2500 : base);
    ped = base * 16 + $urandom_range(0, 15);
    h.sample_2 = pulse_sample(base, amp, 100, 100);
    h.sample_0 = pulse_sample(base, amp, 0, 110);
    h.sample_1 = pulse_sample(base, amp, 40, 120);
    h.sample_3 = pulse_sample(base, amp, 30, 110);
    h.pedestal = 16'(ped);
    // Now and then the pedestal sits right on the peak, so the ratios divide by zero.
    case ($urandom_range(0, 11))
      0: h.pedestal = {h.sample_2, 4'h0};
      1: begin
        h.pedestal = {h.sample_2, 4'h0};
        h.sample_0 = h.sample_2;
        h.sample_1 = h.sample_2;
        h.sample_3 = h.sample_2;
      end
      default: ;
    endcase
    h.noise_rms = 16'($urandom_range(64, 1024));
    case ($urandom_range(0, 15))
      0:       h.strip_gain = '0;
      1:       h.strip_gain = GAIN_ONE - 16'd1;
      2:       h.strip_gain = GAIN_ONE;
      default: h.strip_gain = 16'($urandom_range(3500, 6500));
    endcase
    h.calib_found = ($urandom_range(0, 24) != 0);
    h.status_bad = ($urandom_range(0, 19) == 0);
    h.channel_dead = ($urandom_range(0, 19) == 0);
    h.mc_threshold_1 = 16'($urandom_range(256, 1536));
    h.mc_threshold_2 = 16'($urandom_range(128, 1024));
    return h;
  endfunction

  function automatic hit_in_t noise_hit();
    logic [159:0] bits;
    hit_in_t      h;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    h = bits[$bits(hit_in_t)-1:0];
    if ($urandom_range(0, 4) != 0) h.calib_found = 1'b1;
    return h;
  endfunction

  // Stimulus: directed corner cases first, then randomized phases.
  initial begin : stim_p
    hit_in_t nominal, h;
    nominal.sample_0 = 12'd2900;
    nominal.sample_1 = 12'd2600;
    nominal.sample_2 = 12'd2000;
    nominal.sample_3 = 12'd2800;
    nominal.pedestal = 16'd48008;
    nominal.noise_rms = 16'd384;
    nominal.strip_gain = GAIN_ONE + 16'd512;
    nominal.calib_found = 1'b1;
    nominal.status_bad = 1'b0;
    nominal.channel_dead = 1'b0;
    nominal.mc_threshold_1 = 16'd768;
    nominal.mc_threshold_2 = 16'd256;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // All cuts on, with wide-open shape windows.
    write_reg(CFG_MODE_BITS, CFG_W'(KNOWN_MODES));
    write_reg(CFG_OLDER_ERA, '0);
    write_reg(CFG_DATA_THR_1, CFG_W'(768));
    write_reg(CFG_DATA_THR_2, CFG_W'(256));
    write_reg(CFG_SHAPE_FIRST, {16'h7FFF, 16'h8000});
    write_reg(CFG_SHAPE_SECOND, {16'h7FFF, 16'h8000});
    write_reg(CFG_SHAPE_FOURTH, {16'h7FFF, 16'h8000});
    hit_q.push_back(nominal);
    h = nominal;
    h.calib_found = 1'b0;
    hit_q.push_back(h);
    h = '0;
    h.calib_found = 1'b1;
    hit_q.push_back(h);
    hit_q.push_back('1);
    // Pedestal equal to the peak: positive, negative and zero numerators.
    h = nominal;
    h.pedestal = {h.sample_2, 4'h0};
    hit_q.push_back(h);
    h.sample_0 = 12'd1500;
    hit_q.push_back(h);
    h.sample_0 = h.sample_2;
    h.sample_1 = h.sample_2;
    h.sample_3 = h.sample_2;
    hit_q.push_back(h);
    h = nominal;
    h.strip_gain = '0;
    hit_q.push_back(h);
    h.strip_gain = GAIN_ONE - 16'd1;
    hit_q.push_back(h);
    h.strip_gain = GAIN_ONE;
    hit_q.push_back(h);
    h = nominal;
    h.status_bad = 1'b1;
    hit_q.push_back(h);
    h = nominal;
    h.channel_dead = 1'b1;
    hit_q.push_back(h);
    h = nominal;
    h.pedestal = 16'd16000;
    hit_q.push_back(h);
    wait_drained();

    // Mode zero accepts everything.
    write_reg(CFG_MODE_BITS, '0);
    hit_q.push_back(nominal);
    hit_q.push_back('1);
    wait_drained();

    // Each cut on its own.
    for (int b = 0; b < NUM_CUTS; b++) begin
      write_reg(CFG_MODE_BITS, CFG_W'(1 << b));
      hit_q.push_back(nominal);
      wait_drained();
    end

    // Data cut with the older ratio limits.
    write_reg(CFG_MODE_BITS, CFG_W'(1 << MODE_DATA));
    write_reg(CFG_OLDER_ERA, CFG_W'(1));
    hit_q.push_back(nominal);
    h = nominal;
    h.sample_0 = 12'd1900;
    hit_q.push_back(h);
    wait_drained();

    // Every register at its maximum.
    write_reg(CFG_MODE_BITS, '1);
    write_reg(CFG_DATA_THR_1, '1);
    write_reg(CFG_DATA_THR_2, '1);
    write_reg(CFG_SHAPE_FIRST, '1);
    write_reg(CFG_SHAPE_SECOND, '1);
    write_reg(CFG_SHAPE_FOURTH, '1);
    hit_q.push_back(nominal);
    hit_q.push_back('1);
    wait_drained();

    // Random phases: mostly plausible hits, the rest raw noise.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setup();
      repeat (PHASE_HITS) begin
        if ($urandom_range(0, 9) < 7) hit_q.push_back(shaped_hit());
        else hit_q.push_back(noise_hit());
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0)
      $display("strip_hit_zero_suppression_unit regression: pass");
    else
      $display("strip_hit_zero_suppression_unit regression: fail");
    $finish;
  end

endmodule
